>>> hw/rtl/mas_pkg.sv
// mas_pkg: shared types and constants of the mirror axis search block
// no dependencies

package mas_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int AXIS_W  = 11;
  localparam int CFG_W   = 10;
  localparam int IDX_W   = 2;
  localparam int SCORE_W = 31;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_LOW    = 2'd0;
  localparam logic [IDX_W-1:0] REG_HIGH   = 2'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_AXIS,
    ST_PAIR,
    ST_ROW,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/mirror_axis_search.sv
// mirror_axis_search: frame store and mirror axis search sequencer
// depends on mas_pkg
//
// pixels arrive on in_valid/in_ready in raster order, one request per cycle,
// and are written to an on-chip frame store of MAX_WIDTH*MAX_HEIGHT bytes.
// the request flagged last_pixel starts the search; no pixel is taken until
// the search ends. each candidate axis s from low to high bound is scored
// over every row of each mirrored column pair inside the width, with one
// multiply-accumulate per cycle while a pair is read, set by the two read
// ports of the frame store. the result (axis_half_pixels, best_score) sits
// in an output register on out_valid/out_ready; new pixels are taken while
// it waits, but the next search holds its result until the register is
// free. reset clears control state and restores the default registers;
// the frame store is not cleared. configuration is written on cfg_write
// with cfg_index and cfg_data; the user must write it only while idle,
// the block itself does not enforce this.

module mirror_axis_search
  import mas_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          pixel,
  input  logic                last_pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          axis_half_pixels,
  output logic [SCORE_W-1:0]  best_score
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int EW0   = (AW > AXIS_W) ? AW : AXIS_W;
  localparam int EW    = ((EW0 > WW) ? EW0 : WW) + 1;
  localparam int SW0   = 16 + AW + 1;
  localparam int SUM_W = (SW0 > 32) ? SW0 : 32;

  state_t state, state_next;

  logic signed [9:0]   low_half_axis, high_half_axis;
  logic [8:0]          width_in_use, height_in_use;

  logic [7:0]          mem [DEPTH];
  logic [AW-1:0]       wp;
  logic [7:0]          rd_a, rd_b;
  logic                rd_vld;
  logic [15:0]         prod;
  logic                prod_vld;

  logic [WW-1:0]       w_r, w_clamp;
  logic [YW-1:0]       h_r, h_clamp, y;
  logic [AXIS_W-1:0]   s, s_hi, x0, x1, best_axis, w_ax;
  logic [AW-1:0]       base, addr_a, addr_b;
  logic [SUM_W-1:0]    sum, best;

  logic in_acc, issue, out_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      low_half_axis  <= -10'sd1;
      high_half_axis <= -10'sd1;
      width_in_use   <= 9'd256;
      height_in_use  <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOW:    low_half_axis  <= cfg_data;
        REG_HIGH:   high_half_axis <= cfg_data;
        REG_WIDTH:  width_in_use   <= cfg_data[8:0];
        REG_HEIGHT: height_in_use  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_in_use == 9'd0) begin
      w_clamp = WW'(1);
    end else if (32'(width_in_use) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(width_in_use);
    end
    if (height_in_use == 9'd0) begin
      h_clamp = YW'(1);
    end else if (32'(height_in_use) > MAX_HEIGHT) begin
      h_clamp = YW'(MAX_HEIGHT);
    end else begin
      h_clamp = YW'(height_in_use);
    end
  end

  assign w_ax   = AXIS_W'(w_r);
  assign addr_a = AW'(EW'(base) + EW'(x0));
  assign addr_b = AW'(EW'(base) + EW'(x1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && last_pixel) state_next = ST_START;
      end
      ST_START: state_next = ST_AXIS;
      ST_AXIS: begin
        state_next = (s > s_hi) ? ST_DONE : ST_PAIR;
      end
      ST_PAIR: begin
        state_next = ({1'b0, x0, 1'b0} < {2'b0, s}) ? ST_ROW : ST_WAIT;
      end
      ST_ROW: begin
        if (y == h_r - YW'(1)) state_next = ST_PAIR;
      end
      ST_WAIT: begin
        if (!rd_vld && !prod_vld) state_next = ST_AXIS;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_ROW:  issue    = 1'b1;
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wp] <= pixel;
    end
    if (issue) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (in_acc) begin
      if (last_pixel || wp == AW'(DEPTH - 1)) begin
        wp <= '0;
      end else begin
        wp <= wp + AW'(1);
      end
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= issue;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= 16'(rd_a * rd_b);
    end
  end

  // search counters
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        w_r       <= w_clamp;
        h_r       <= h_clamp;
        s         <= low_half_axis[9] ? AXIS_W'(1) : AXIS_W'(low_half_axis[8:0]);
        s_hi      <= high_half_axis[9] ? AXIS_W'({AXIS_W'(w_clamp), 1'b0} - 12'd2)
                                       : AXIS_W'(high_half_axis[8:0]);
        best_axis <= AXIS_W'((low_half_axis[9] ? AXIS_W'(1)
                                               : AXIS_W'(low_half_axis[8:0]))
                    + (high_half_axis[9] ? AXIS_W'({AXIS_W'(w_clamp), 1'b0} - 12'd2)
                                         : AXIS_W'(high_half_axis[8:0])));
        best      <= '0;
      end
      ST_AXIS: begin
        sum <= '0;
        x0  <= (s >= w_ax) ? s - w_ax + AXIS_W'(1) : '0;
      end
      ST_PAIR: begin
        x1   <= s - x0;
        y    <= '0;
        base <= '0;
        if (prod_vld) sum <= sum + SUM_W'(prod);
      end
      ST_ROW: begin
        y    <= y + YW'(1);
        base <= AW'(EW'(base) + EW'(w_r));
        if (y == h_r - YW'(1)) x0 <= x0 + AXIS_W'(1);
        if (prod_vld) sum <= sum + SUM_W'(prod);
      end
      ST_WAIT: begin
        if (prod_vld) sum <= sum + SUM_W'(prod);
        if (!rd_vld && !prod_vld) begin
          if (sum > best) begin
            best      <= sum;
            best_axis <= s;
          end
          s <= s + AXIS_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      axis_half_pixels <= best_axis[9:0];
      best_score       <= (best > SUM_W'(SCORE_MAX)) ? SCORE_MAX : best[SCORE_W-1:0];
    end
  end

endmodule

>>> bench/axis_score_checker.sv
`timescale 1ns / 1ps
// axis_score_checker: watches the config port and both request channels of
// mirror_axis_search, predicts each axis result and compares it in order
// depends on mas_pkg

module axis_score_checker
  import mas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         pixel,
  input  logic               last_pixel,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [9:0]         axis_half_pixels,
  input  logic [SCORE_W-1:0] best_score,
  output int                 mismatch_count,
  output int                 pending_results
);

  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    logic [9:0]         axis;
    logic [SCORE_W-1:0] score;
  } axis_result_t;

  logic [7:0]       frame_mem [STORE_DEPTH];
  logic [15:0]      wr_addr;
  logic [CFG_W-1:0] low_bound;
  logic [CFG_W-1:0] high_bound;
  logic [8:0]       width_reg;
  logic [8:0]       height_reg;
  axis_result_t     expected_axis_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic axis_result_t search_axis();
    axis_result_t     res;
    int               w;
    int               h;
    int               lo;
    int               hi;
    int               best_axis;
    longint unsigned  sum;
    longint unsigned  best;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : height_reg);
    lo = $signed(low_bound);
    hi = $signed(high_bound);
    if (lo < 0) lo = 1;
    if (hi < 0) hi = 2 * w - 2;
    best_axis = lo + hi;
    best = 0;
    for (int s = lo; s <= hi; s++) begin
      sum = 0;
      for (int x0 = 0; 2 * x0 < s; x0++) begin
        if (s - x0 < w) begin
          for (int y = 0; y < h; y++) begin
            sum += longint'(frame_mem[(y * w + x0) % STORE_DEPTH])
                 * longint'(frame_mem[(y * w + s - x0) % STORE_DEPTH]);
          end
        end
      end
      if (sum > best) begin
        best = sum;
        best_axis = s;
      end
    end
    res.axis = 10'(best_axis);
    res.score = (best > SCORE_MAX) ? SCORE_MAX : SCORE_W'(best);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    axis_result_t want;
    if (rst) begin
      wr_addr = '0;
      low_bound = '1;
      high_bound = '1;
      width_reg = 9'(MAX_WIDTH_DEF);
      height_reg = 9'(MAX_HEIGHT_DEF);
      expected_axis_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LOW:    low_bound = cfg_data;
          REG_HIGH:   high_bound = cfg_data;
          REG_WIDTH:  width_reg = cfg_data[8:0];
          REG_HEIGHT: height_reg = cfg_data[8:0];
          default: ;
        endcase
      end
      // result leaving this edge belongs to an earlier frame than any
      // last request accepted at the same edge
      if (out_valid && out_ready) begin
        if (expected_axis_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result axis %0d score %0d",
                                    axis_half_pixels, best_score));
        end else begin
          want = expected_axis_q.pop_front();
          if (axis_half_pixels !== want.axis)
            report_mismatch($sformatf("axis_half_pixels got %0d expected %0d",
                                      axis_half_pixels, want.axis));
          if (best_score !== want.score)
            report_mismatch($sformatf("best_score got %0d expected %0d",
                                      best_score, want.score));
        end
      end
      if (in_valid && in_ready) begin
        frame_mem[wr_addr] = pixel;
        wr_addr = wr_addr + 16'd1;
        if (last_pixel) begin
          wr_addr = '0;
          expected_axis_q.insert(expected_axis_q.size(), search_axis());
        end
      end
    end
    pending_results = expected_axis_q.size();
  end

endmodule

>>> bench/tb_mirror_axis_search.sv
`timescale 1ns / 1ps
// tb_mirror_axis_search: drives frames and register settings into
// mirror_axis_search and gives the verdict
// depends on mas_pkg, mirror_axis_search and axis_score_checker

module tb_mirror_axis_search;
  import mas_pkg::*;

  localparam int STORE_DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int RANDOM_ITEMS = 650;
  localparam int MIN_FRAMES   = 20;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 20;
  localparam int IDLE_LIMIT   = 300000;
  localparam logic [CFG_W-1:0] AXIS_AUTO = '1;

  typedef enum {PAT_RANDOM, PAT_SPARSE, PAT_ZERO, PAT_MAX, PAT_TINY} pixel_pattern_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         pixel;
  logic               last_pixel;
  logic               out_valid;
  logic               out_ready;
  logic [9:0]         axis_half_pixels;
  logic [SCORE_W-1:0] best_score;
  int                 mismatch_count;
  int                 pending_results;

  int frame_pixels;
  int filled_depth;
  int item_count;
  int frame_count;
  int in_gap_rate;
  int out_gap_rate;
  int idle_cycles;
  bit hold_request;

  mirror_axis_search DUT (.*);

  axis_score_checker score_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_mirror_axis_search NOT OK");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (out_gap_rate != 0 && $urandom_range(1, out_gap_rate) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int clamp_dim(input logic [8:0] v, input int maxv);
    return (v == 0) ? 1 : ((v > maxv) ? maxv : v);
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] lo, hi, wd, ht);
    logic [CFG_W-1:0] value [4];
    wait_idle();
    value[REG_LOW] = lo;
    value[REG_HIGH] = hi;
    value[REG_WIDTH] = wd;
    value[REG_HEIGHT] = ht;
    for (int i = 0; i < $size(value); i++) begin
      cfg_write <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= value[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    frame_pixels = clamp_dim(wd[8:0], MAX_WIDTH_DEF) * clamp_dim(ht[8:0], MAX_HEIGHT_DEF);
  endtask

  task automatic send_pixel(input logic [7:0] value, input logic is_last);
    if (in_gap_rate != 0 && $urandom_range(1, in_gap_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= value;
    last_pixel <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input pixel_pattern_t pat);
    logic [7:0] value;
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_ZERO:   value = 8'd0;
        PAT_MAX:    value = 8'hFF;
        PAT_TINY:   value = 8'($urandom_range(0, 3));
        PAT_SPARSE: value = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0;
        default:    value = 8'($urandom);
      endcase
      send_pixel(value, i == len - 1);
    end
    if (len > filled_depth) filled_depth = (len > STORE_DEPTH) ? STORE_DEPTH : len;
    item_count += len;
    frame_count++;
  endtask

  // short frames only once every address they read has been written
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 8) return frame_pixels + $urandom_range(1, 5);
    if (r == 9 && filled_depth >= frame_pixels && frame_pixels > 1)
      return $urandom_range(1, frame_pixels - 1);
    return frame_pixels;
  endfunction

  function automatic logic [CFG_W-1:0] pick_bound(input int w);
    case ($urandom_range(0, 9))
      0:       return AXIS_AUTO;
      1:       return CFG_W'($urandom_range(10'h200, 10'h3FE));
      2:       return '0;
      3:       return CFG_W'($urandom_range(510, 511));
      default: return CFG_W'($urandom_range(0, 2 * w));
    endcase
  endfunction

  task automatic pick_config();
    logic [CFG_W-1:0] wd;
    logic [CFG_W-1:0] ht;
    int               sel;
    int               w;
    sel = $urandom_range(0, 29);
    if (sel == 0) wd = CFG_W'($urandom);
    else if (sel == 1) wd = '0;
    else if (sel < 6) wd = CFG_W'($urandom_range(1, 3));
    else wd = CFG_W'($urandom_range(1, 12));
    w = clamp_dim(wd[8:0], MAX_WIDTH_DEF);
    // wide images stay one row high to keep the search short
    if (w > 24) ht = CFG_W'($urandom_range(0, 1));
    else if (w <= 2 && $urandom_range(0, 5) == 0) ht = CFG_W'($urandom);
    else ht = CFG_W'($urandom_range(0, 8));
    configure(pick_bound(w), pick_bound(w), wd, ht);
  endtask

  function automatic int pick_rate();
    return ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(1, 3));
  endfunction

  initial begin
    int             start_items;
    int             start_frames;
    pixel_pattern_t pat;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    last_pixel = 1'b0;
    out_ready = 1'b0;
    hold_request = 1'b0;
    filled_depth = 0;
    item_count = 0;
    frame_count = 0;
    in_gap_rate = 4;
    out_gap_rate = 4;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames
    configure(AXIS_AUTO, AXIS_AUTO, 10'd2, 10'd1);
    send_frame(2, PAT_MAX);
    send_frame(2, PAT_ZERO);
    configure(10'd0, 10'd510, 10'd3, 10'd2);
    send_frame(6, PAT_RANDOM);
    // empty axis range on a short frame
    configure(10'd5, 10'd2, 10'd3, 10'd2);
    send_frame(2, PAT_TINY);
    // zero sizes count as one
    configure(AXIS_AUTO, 10'd511, 10'd0, 10'd0);
    send_frame(1, PAT_MAX);
    configure(10'h200, 10'h3FE, 10'd2, 10'd2);
    send_frame(7, PAT_RANDOM);
    configure(10'd0, 10'd0, 10'd2, 10'd2);
    send_frame(4, PAT_MAX);

    // size extremes
    configure(AXIS_AUTO, AXIS_AUTO, 10'd256, 10'd1);
    send_frame(256, PAT_SPARSE);
    configure(10'd0, 10'd510, 10'd2, 10'd256);
    send_frame(512, PAT_RANDOM);
    configure(10'd510, 10'd510, 10'h1FF, 10'h200);
    send_frame(256, PAT_RANDOM);

    // results back up while the receiver holds off
    in_gap_rate = 0;
    out_gap_rate = 0;
    configure(AXIS_AUTO, AXIS_AUTO, 10'd2, 10'd2);
    hold_request = 1'b1;
    repeat (8) send_frame(4, PAT_RANDOM);
    wait_idle();

    start_items = item_count;
    start_frames = frame_count;
    while (item_count - start_items < RANDOM_ITEMS || frame_count - start_frames < MIN_FRAMES)
    begin
      if (item_count - start_items > RANDOM_ITEMS * 85 / 100) begin
        in_gap_rate = 0;
        out_gap_rate = 0;
      end else begin
        in_gap_rate = pick_rate();
        out_gap_rate = pick_rate();
      end
      pick_config();
      repeat ($urandom_range(1, 6)) begin
        pat = ($urandom_range(0, 3) != 0) ? PAT_RANDOM
                                           : pixel_pattern_t'($urandom_range(0, 4));
        send_frame(pick_length(), pat);
      end
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_mirror_axis_search OK");
    end else begin
      $display("tb_mirror_axis_search NOT OK");
    end
    $finish;
  end

endmodule
